[hdl/ecs_pkg.sv]
// Shared types and constants for the exclusive cost stack.
// Depends on nothing; imported by ecs_store, ecs_ctrl and the top level.
`timescale 1ns / 1ps

package ecs_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned VALUE_W         = 64;
  localparam int unsigned DEPTH_W         = 7;

  typedef enum logic [1:0] {
    ACT_PUSH     = 2'd0,
    ACT_POP      = 2'd1,
    ACT_ACCT_POP = 2'd2,
    ACT_CMP      = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_ACCUM
  } state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] result_value;
    logic               top_differs;
    logic [1:0]         status;
    logic [DEPTH_W-1:0] depth;
  } result_t;

  typedef struct packed {
    logic start_we;
    logic cost_we;
  } mem_ctl_t;

endpackage

[hdl/ecs_store.sv]
// Entry storage: start-counter and child-cost memories, one write and one
// registered read per cycle each. Depends on ecs_pkg.
`timescale 1ns / 1ps

module ecs_store
  import ecs_pkg::*;
#(
  parameter int unsigned DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  mem_ctl_t           ctl_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [VALUE_W-1:0] start_wdata_i,
  input  logic [VALUE_W-1:0] cost_wdata_i,
  input  logic [AW-1:0]      rd_addr_i,
  output logic [VALUE_W-1:0] start_rdata_o,
  output logic [VALUE_W-1:0] cost_rdata_o
);

  logic [VALUE_W-1:0] start_mem [DEPTH];
  logic [VALUE_W-1:0] cost_mem  [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.start_we) begin
      start_mem[wr_addr_i] <= start_wdata_i;
    end
    start_rdata_o <= start_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cost_we) begin
      cost_mem[wr_addr_i] <= cost_wdata_i;
    end
    cost_rdata_o <= cost_mem[rd_addr_i];
  end

endmodule

[hdl/ecs_ctrl.sv]
// Sequencer and datapath: reads the top entry, updates count and parent
// accumulator, builds the result. Depends on ecs_pkg.
`timescale 1ns / 1ps

module ecs_ctrl
  import ecs_pkg::*;
#(
  parameter int unsigned DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  item_t              item_i,
  output logic               busy_o,
  output logic               valid_o,
  output result_t            result_o,
  output mem_ctl_t           mem_ctl_o,
  output logic [AW-1:0]      wr_addr_o,
  output logic [VALUE_W-1:0] start_wdata_o,
  output logic [VALUE_W-1:0] cost_wdata_o,
  output logic [AW-1:0]      rd_addr_o,
  input  logic [VALUE_W-1:0] start_rdata_i,
  input  logic [VALUE_W-1:0] cost_rdata_i
);

  state_e             state_q, state_d;
  action_e            act_q, act_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [VALUE_W-1:0] diff_q, diff_d;
  logic [VALUE_W-1:0] top_cost_q, top_cost_d;
  logic               differs_q, differs_d;
  logic               valid_q, valid_d;
  result_t            res_q, res_d;
  logic               empty, full;

  assign empty  = (cnt_q == '0);
  assign full   = (cnt_q == CW'(DEPTH));
  assign busy_o = (state_q != S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (act_q == ACT_ACCT_POP && !empty) begin
          state_d = S_ACCUM;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_ACCUM: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    act_d         = act_q;
    val_d         = val_q;
    cnt_d         = cnt_q;
    diff_d        = diff_q;
    top_cost_d    = top_cost_q;
    differs_d     = differs_q;
    valid_d       = 1'b0;
    res_d         = res_q;
    mem_ctl_o     = '0;
    wr_addr_o     = AW'(cnt_q);
    start_wdata_o = val_q;
    cost_wdata_o  = '0;
    // top entry while idle, parent entry during the read cycle
    rd_addr_o     = (state_q == S_READ) ? AW'(cnt_q - CW'(2)) : AW'(cnt_q - CW'(1));

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          act_d = action_e'(item_i.action);
          val_d = item_i.value;
        end
      end
      S_READ: begin
        differs_d          = empty || (val_q != start_rdata_i);
        res_d.result_value = '0;
        res_d.status       = ST_OK;
        unique case (act_q)
          ACT_PUSH: begin
            valid_d = 1'b1;
            if (full) begin
              res_d.status = ST_OVERFLOW;
            end else begin
              mem_ctl_o.start_we = 1'b1;
              mem_ctl_o.cost_we  = 1'b1;
              cnt_d              = cnt_q + CW'(1);
            end
          end
          ACT_POP: begin
            valid_d = 1'b1;
            if (empty) begin
              res_d.status = ST_UNDERFLOW;
            end else begin
              cnt_d              = cnt_q - CW'(1);
              res_d.result_value = start_rdata_i;
            end
          end
          ACT_ACCT_POP: begin
            if (empty) begin
              valid_d      = 1'b1;
              res_d.status = ST_UNDERFLOW;
            end else begin
              diff_d     = val_q - start_rdata_i;
              top_cost_d = cost_rdata_i;
            end
          end
          ACT_CMP: valid_d = 1'b1;
          default: valid_d = 1'b1;
        endcase
        res_d.top_differs = differs_d;
        res_d.depth       = DEPTH_W'(cnt_d);
      end
      S_ACCUM: begin
        // cost_rdata_i now holds the parent accumulator
        valid_d            = 1'b1;
        cnt_d              = cnt_q - CW'(1);
        res_d.result_value = diff_q - top_cost_q;
        res_d.status       = ST_OK;
        res_d.top_differs  = differs_q;
        res_d.depth        = DEPTH_W'(cnt_d);
        if (cnt_q > CW'(1)) begin
          mem_ctl_o.cost_we = 1'b1;
          wr_addr_o         = AW'(cnt_q - CW'(2));
          cost_wdata_o      = cost_rdata_i + diff_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    val_q      <= val_d;
    diff_q     <= diff_d;
    top_cost_q <= top_cost_d;
    differs_q  <= differs_d;
    res_q      <= res_d;
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

[hdl/exclusive_cost_stack_unit.sv]
// Exclusive cost stack, top level: controller plus entry memories.
// Depends on ecs_pkg, ecs_store and ecs_ctrl.
//
// Usage:
//   A command (action, value) is taken at a clock edge with start_i high and
//   busy_o low. Actions: push, plain pop, accounting pop, compare only.
//   Each command gives exactly one result on result_o, shown for one cycle
//   with valid_o high; the receiver must take it then, it cannot stall.
// Sequencing:
//   The top entry is read from the registered entry memories when a command
//   is taken; push, plain pop and compare give their result from the read
//   state. An accounting pop then goes on to an accumulate state, which
//   reads and rewrites the parent's accumulator. A new command is not
//   taken until the last one has given its result.
//   busy_o is low again in the cycle the result is shown, so the next
//   command may be taken while valid_o is high.
// Reset:
//   rst_ni clears the entry count and the sequencer; memory contents are
//   left as they are and are only used below the entry count.
`timescale 1ns / 1ps

module exclusive_cost_stack_unit
  import ecs_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  item_t   item_i,
  output logic    busy_o,
  output logic    valid_o,
  output result_t result_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  mem_ctl_t           mem_ctl;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic [VALUE_W-1:0] start_wdata;
  logic [VALUE_W-1:0] cost_wdata;
  logic [VALUE_W-1:0] start_rdata;
  logic [VALUE_W-1:0] cost_rdata;

  ecs_ctrl #(
    .DEPTH(STACK_DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .item_i       (item_i),
    .busy_o       (busy_o),
    .valid_o      (valid_o),
    .result_o     (result_o),
    .mem_ctl_o    (mem_ctl),
    .wr_addr_o    (wr_addr),
    .start_wdata_o(start_wdata),
    .cost_wdata_o (cost_wdata),
    .rd_addr_o    (rd_addr),
    .start_rdata_i(start_rdata),
    .cost_rdata_i (cost_rdata)
  );

  ecs_store #(
    .DEPTH(STACK_DEPTH),
    .AW   (AW)
  ) u_store (
    .clk_i        (clk_i),
    .ctl_i        (mem_ctl),
    .wr_addr_i    (wr_addr),
    .start_wdata_i(start_wdata),
    .cost_wdata_i (cost_wdata),
    .rd_addr_i    (rd_addr),
    .start_rdata_o(start_rdata),
    .cost_rdata_o (cost_rdata)
  );

  // a result always lands with the sequencer back in idle
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o)
    else $error("result shown while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted transaction did not start");

  a_we_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_ctl.start_we || mem_ctl.cost_we) |-> busy_o)
    else $error("memory write outside a transaction");

  // a push writes a fresh entry into both memories
  a_push_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl.start_we |-> mem_ctl.cost_we)
    else $error("start written without its accumulator");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.status == ST_OVERFLOW) |->
      result_o.depth == DEPTH_W'(STACK_DEPTH))
    else $error("overflow reported below full depth");

endmodule
